/* rtl/strm_pkg.sv */
// Shared types and constants for the streaming two-run merger.
package strm_pkg;

    localparam int WORD_W       = 32;
    localparam int QUEUE_DEPTH  = 32;
    localparam int MAX_RESULTS  = 33;
    localparam int CMDQ_DEPTH   = 2;
    localparam int OUTQ_DEPTH   = 4;

    localparam int PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int LEN_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int TAKEN_W      = $clog2(QUEUE_DEPTH + 2);
    localparam int EMIT_W       = $clog2(MAX_RESULTS);
    localparam int CMDQ_PTR_W   = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W   = $clog2(CMDQ_DEPTH + 1);
    localparam int OUTQ_PTR_W   = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W   = $clog2(OUTQ_DEPTH + 1);

    localparam logic [WORD_W-1:0] END_WORD = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_HEADER = 2'd0,
        CMD_END    = 2'd1,
        CMD_DATA   = 2'd2
    } cmd_kind_t;

    // Header commands carry the clipped run length in the low bits of data.
    typedef struct packed {
        cmd_kind_t          kind;
        logic [WORD_W-1:0]  data;
    } cmd_t;

    typedef struct packed {
        logic [WORD_W-1:0]  value;
        logic               last;
    } result_t;

    typedef enum logic [7:0] {
        PH_WAIT     = 8'b0000_0001,
        PH_FETCH_A  = 8'b0000_0010,
        PH_FETCH_B  = 8'b0000_0100,
        PH_COMPARE  = 8'b0000_1000,
        PH_DFETCH_A = 8'b0001_0000,
        PH_DFETCH_B = 8'b0010_0000,
        PH_DRAIN_A  = 8'b0100_0000,
        PH_DRAIN_B  = 8'b1000_0000
    } merge_phase_t;

endpackage

/* rtl/strm_intake.sv */
// Front end: sorts incoming words into header, terminator and data commands.
module strm_intake (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [strm_pkg::WORD_W-1:0] word,
    input  logic                        push,
    output logic                        full,
    output logic                        cmdq_push,
    output strm_pkg::cmd_t              cmdq_cmd,
    input  logic                        cmdq_full
);

    logic                       hdr_mode_reg;
    logic                       hdr_mode_next;
    logic [strm_pkg::LEN_W-1:0] hdr_len;

    assign full      = cmdq_full;
    assign cmdq_push = push && !cmdq_full;

    // zero acts as one, anything above the queue depth clips to it
    always_comb
    begin
        if (word == '0)
            hdr_len = strm_pkg::LEN_W'(1);
        else if (word > strm_pkg::WORD_W'(strm_pkg::QUEUE_DEPTH))
            hdr_len = strm_pkg::LEN_W'(strm_pkg::QUEUE_DEPTH);
        else
            hdr_len = word[strm_pkg::LEN_W-1:0];
    end

    always_comb
    begin
        hdr_mode_next = hdr_mode_reg;
        cmdq_cmd.data = word;
        if (hdr_mode_reg)
        begin
            cmdq_cmd.kind = strm_pkg::CMD_HEADER;
            cmdq_cmd.data = strm_pkg::WORD_W'(hdr_len);
            hdr_mode_next = 1'b0;
        end
        else if (word == strm_pkg::END_WORD)
        begin
            cmdq_cmd.kind = strm_pkg::CMD_END;
            hdr_mode_next = 1'b1;
        end
        else
        begin
            cmdq_cmd.kind = strm_pkg::CMD_DATA;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hdr_mode_reg <= 1'b1;
        else if (cmdq_push)
            hdr_mode_reg <= hdr_mode_next;
    end

endmodule

/* rtl/strm_cmd_queue.sv */
// Short command queue between the intake front end and the merge engine.
module strm_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  strm_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output strm_pkg::cmd_t head_cmd,
    output logic           empty
);

    strm_pkg::cmd_t                  slot_reg [strm_pkg::CMDQ_DEPTH];
    logic [strm_pkg::CMDQ_PTR_W-1:0] wr_ptr_reg;
    logic [strm_pkg::CMDQ_PTR_W-1:0] rd_ptr_reg;
    logic [strm_pkg::CMDQ_CNT_W-1:0] count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign full     = (count_reg == strm_pkg::CMDQ_CNT_W'(strm_pkg::CMDQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == strm_pkg::CMDQ_PTR_W'(strm_pkg::CMDQ_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == strm_pkg::CMDQ_PTR_W'(strm_pkg::CMDQ_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* rtl/strm_engine.sv */
// Back end: run queues, merge sequencer and result queue.
module strm_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  strm_pkg::cmd_t              cmd,
    input  logic                        cmd_empty,
    output logic                        cmd_pop,
    output logic [strm_pkg::WORD_W-1:0] merged_value,
    output logic                        group_end,
    output logic                        empty,
    input  logic                        pop
);

    // run queues
    logic [strm_pkg::WORD_W-1:0] mem_a [strm_pkg::QUEUE_DEPTH];
    logic [strm_pkg::WORD_W-1:0] mem_b [strm_pkg::QUEUE_DEPTH];
    logic [strm_pkg::PTR_W-1:0]  a_wr_ptr_reg, a_rd_ptr_reg;
    logic [strm_pkg::PTR_W-1:0]  b_wr_ptr_reg, b_rd_ptr_reg;
    logic [strm_pkg::LEN_W-1:0]  a_cnt_reg, b_cnt_reg;
    logic [strm_pkg::WORD_W-1:0] head_a_reg, head_b_reg;
    logic                        a_wr, b_wr, a_rd, b_rd;

    // sequencer
    strm_pkg::merge_phase_t       phase_reg, phase_next;
    logic                         run_reg, run_next;
    logic                         to_b_reg, to_b_next;
    logic [strm_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [strm_pkg::TAKEN_W-1:0] taken_a_reg, taken_a_next;
    logic [strm_pkg::TAKEN_W-1:0] taken_b_reg, taken_b_next;
    logic [strm_pkg::EMIT_W-1:0]  emit_cnt_reg, emit_cnt_next;
    logic [strm_pkg::TAKEN_W-1:0] len_ext;
    logic                         a_empty, b_empty, a_full, b_full;

    // result queue
    strm_pkg::result_t               outq_reg [strm_pkg::OUTQ_DEPTH];
    logic [strm_pkg::OUTQ_PTR_W-1:0] oq_wr_ptr_reg, oq_rd_ptr_reg;
    logic [strm_pkg::OUTQ_CNT_W-1:0] oq_cnt_reg;
    logic                            oq_full;
    logic                            res_push;
    logic                            res_pop;
    strm_pkg::result_t               res;

    assign len_ext = strm_pkg::TAKEN_W'(len_reg);
    assign a_empty = (a_cnt_reg == '0);
    assign b_empty = (b_cnt_reg == '0);
    assign a_full  = (a_cnt_reg == strm_pkg::LEN_W'(strm_pkg::QUEUE_DEPTH));
    assign b_full  = (b_cnt_reg == strm_pkg::LEN_W'(strm_pkg::QUEUE_DEPTH));

    always_comb
    begin
        phase_next    = phase_reg;
        run_next      = run_reg;
        to_b_next     = to_b_reg;
        len_next      = len_reg;
        taken_a_next  = taken_a_reg;
        taken_b_next  = taken_b_reg;
        emit_cnt_next = emit_cnt_reg;
        cmd_pop       = 1'b0;
        a_wr          = 1'b0;
        b_wr          = 1'b0;
        a_rd          = 1'b0;
        b_rd          = 1'b0;
        res_push      = 1'b0;
        res.value     = head_a_reg;
        res.last      = 1'b0;

        if (!run_reg)
        begin
            // apply one command, then let the merge run until it stalls or hits the burst cap
            if (!cmd_empty)
            begin
                cmd_pop       = 1'b1;
                run_next      = 1'b1;
                emit_cnt_next = '0;
                case (cmd.kind)
                    strm_pkg::CMD_HEADER:
                    begin
                        len_next  = cmd.data[strm_pkg::LEN_W-1:0];
                        to_b_next = 1'b0;
                    end
                    strm_pkg::CMD_DATA:
                    begin
                        // a word for a full queue is dropped; target stays
                        if (to_b_reg)
                        begin
                            if (!b_full)
                            begin
                                b_wr      = 1'b1;
                                to_b_next = 1'b0;
                            end
                        end
                        else if (!a_full)
                        begin
                            a_wr      = 1'b1;
                            to_b_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else
        begin
            case (phase_reg)
                strm_pkg::PH_WAIT:
                begin
                    if (a_empty || b_empty)
                        run_next = 1'b0;
                    else
                    begin
                        a_rd         = 1'b1;
                        b_rd         = 1'b1;
                        taken_a_next = strm_pkg::TAKEN_W'(1);
                        taken_b_next = strm_pkg::TAKEN_W'(1);
                        phase_next   = strm_pkg::PH_COMPARE;
                    end
                end
                strm_pkg::PH_FETCH_A:
                begin
                    if (a_empty)
                        run_next = 1'b0;
                    else
                    begin
                        a_rd         = 1'b1;
                        taken_a_next = taken_a_reg + 1'b1;
                        phase_next   = strm_pkg::PH_COMPARE;
                    end
                end
                strm_pkg::PH_FETCH_B:
                begin
                    if (b_empty)
                        run_next = 1'b0;
                    else
                    begin
                        b_rd         = 1'b1;
                        taken_b_next = taken_b_reg + 1'b1;
                        phase_next   = strm_pkg::PH_COMPARE;
                    end
                end
                strm_pkg::PH_COMPARE:
                begin
                    if (!oq_full)
                    begin
                        res_push = 1'b1;
                        if (head_a_reg < head_b_reg)
                        begin
                            res.value  = head_a_reg;
                            phase_next = (taken_a_reg < len_ext) ? strm_pkg::PH_FETCH_A
                                                                 : strm_pkg::PH_DRAIN_B;
                        end
                        else
                        begin
                            res.value  = head_b_reg;
                            phase_next = (taken_b_reg < len_ext) ? strm_pkg::PH_FETCH_B
                                                                 : strm_pkg::PH_DRAIN_A;
                        end
                    end
                end
                strm_pkg::PH_DFETCH_A:
                begin
                    if (a_empty)
                        run_next = 1'b0;
                    else
                    begin
                        a_rd       = 1'b1;
                        phase_next = strm_pkg::PH_DRAIN_A;
                    end
                end
                strm_pkg::PH_DFETCH_B:
                begin
                    if (b_empty)
                        run_next = 1'b0;
                    else
                    begin
                        b_rd       = 1'b1;
                        phase_next = strm_pkg::PH_DRAIN_B;
                    end
                end
                strm_pkg::PH_DRAIN_A:
                begin
                    if (!oq_full)
                    begin
                        res_push     = 1'b1;
                        res.value    = head_a_reg;
                        res.last     = !(taken_a_reg < len_ext);
                        taken_a_next = taken_a_reg + 1'b1;
                        phase_next   = res.last ? strm_pkg::PH_WAIT : strm_pkg::PH_DFETCH_A;
                    end
                end
                strm_pkg::PH_DRAIN_B:
                begin
                    if (!oq_full)
                    begin
                        res_push     = 1'b1;
                        res.value    = head_b_reg;
                        res.last     = !(taken_b_reg < len_ext);
                        taken_b_next = taken_b_reg + 1'b1;
                        phase_next   = res.last ? strm_pkg::PH_WAIT : strm_pkg::PH_DFETCH_B;
                    end
                end
                default:
                begin
                    phase_next = strm_pkg::PH_WAIT;
                end
            endcase

            // burst cap per command
            if (res_push)
            begin
                emit_cnt_next = emit_cnt_reg + 1'b1;
                if (emit_cnt_reg == strm_pkg::EMIT_W'(strm_pkg::MAX_RESULTS - 1))
                    run_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= strm_pkg::PH_WAIT;
            run_reg      <= 1'b0;
            to_b_reg     <= 1'b0;
            len_reg      <= '0;
            taken_a_reg  <= '0;
            taken_b_reg  <= '0;
            emit_cnt_reg <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            run_reg      <= run_next;
            to_b_reg     <= to_b_next;
            len_reg      <= len_next;
            taken_a_reg  <= taken_a_next;
            taken_b_reg  <= taken_b_next;
            emit_cnt_reg <= emit_cnt_next;
        end
    end

    // queue storage; read data is the head register
    always_ff @(posedge clk)
    begin
        if (a_wr)
            mem_a[a_wr_ptr_reg] <= cmd.data;
        if (a_rd)
            head_a_reg <= mem_a[a_rd_ptr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (b_wr)
            mem_b[b_wr_ptr_reg] <= cmd.data;
        if (b_rd)
            head_b_reg <= mem_b[b_rd_ptr_reg];
    end

    // pushes and pops of a run queue never fall in the same cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_wr_ptr_reg <= '0;
            a_rd_ptr_reg <= '0;
            a_cnt_reg    <= '0;
            b_wr_ptr_reg <= '0;
            b_rd_ptr_reg <= '0;
            b_cnt_reg    <= '0;
        end
        else
        begin
            if (a_wr)
            begin
                a_wr_ptr_reg <= (a_wr_ptr_reg == strm_pkg::PTR_W'(strm_pkg::QUEUE_DEPTH - 1))
                                ? '0 : a_wr_ptr_reg + 1'b1;
                a_cnt_reg    <= a_cnt_reg + 1'b1;
            end
            else if (a_rd)
            begin
                a_rd_ptr_reg <= (a_rd_ptr_reg == strm_pkg::PTR_W'(strm_pkg::QUEUE_DEPTH - 1))
                                ? '0 : a_rd_ptr_reg + 1'b1;
                a_cnt_reg    <= a_cnt_reg - 1'b1;
            end
            if (b_wr)
            begin
                b_wr_ptr_reg <= (b_wr_ptr_reg == strm_pkg::PTR_W'(strm_pkg::QUEUE_DEPTH - 1))
                                ? '0 : b_wr_ptr_reg + 1'b1;
                b_cnt_reg    <= b_cnt_reg + 1'b1;
            end
            else if (b_rd)
            begin
                b_rd_ptr_reg <= (b_rd_ptr_reg == strm_pkg::PTR_W'(strm_pkg::QUEUE_DEPTH - 1))
                                ? '0 : b_rd_ptr_reg + 1'b1;
                b_cnt_reg    <= b_cnt_reg - 1'b1;
            end
        end
    end

    // result queue
    assign oq_full      = (oq_cnt_reg == strm_pkg::OUTQ_CNT_W'(strm_pkg::OUTQ_DEPTH));
    assign empty        = (oq_cnt_reg == '0);
    assign res_pop      = pop && !empty;
    assign merged_value = outq_reg[oq_rd_ptr_reg].value;
    assign group_end    = outq_reg[oq_rd_ptr_reg].last;

    always_ff @(posedge clk)
    begin
        if (res_push)
            outq_reg[oq_wr_ptr_reg] <= res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_ptr_reg <= '0;
            oq_rd_ptr_reg <= '0;
            oq_cnt_reg    <= '0;
        end
        else
        begin
            if (res_push)
                oq_wr_ptr_reg <= (oq_wr_ptr_reg == strm_pkg::OUTQ_PTR_W'(strm_pkg::OUTQ_DEPTH - 1))
                                 ? '0 : oq_wr_ptr_reg + 1'b1;
            if (res_pop)
                oq_rd_ptr_reg <= (oq_rd_ptr_reg == strm_pkg::OUTQ_PTR_W'(strm_pkg::OUTQ_DEPTH - 1))
                                 ? '0 : oq_rd_ptr_reg + 1'b1;
            if (res_push && !res_pop)
                oq_cnt_reg <= oq_cnt_reg + 1'b1;
            else if (res_pop && !res_push)
                oq_cnt_reg <= oq_cnt_reg - 1'b1;
        end
    end

endmodule

/* rtl/streaming_two_run_merger.sv */
// Top level of the streaming two-run merger.
//
// The first word after reset, and the first word after each 0xFFFFFFFF
// terminator, is a header giving the run length L (0 reads as 1, values
// above the 32-entry queue depth clip to 32). Following data words go in
// turn to run queue A and run queue B; a word aimed at a full queue is
// dropped and the next data word tries the same queue again. The merge
// engine takes L words from each queue, emits the smaller head (B wins a
// tie) and, once one run is used up, drains the rest of the other;
// group_end marks the last word of each 2L group. A header seen mid-merge
// takes effect at once, and leftover data stays queued for later groups.
// Timing: the front end takes a word in a cycle into a two-entry command
// queue while that queue is not full. The back end is a single sequencer
// that applies each command and then steps the merge: a fetch from a run
// queue and a compare or drain step are separate steps. The sequencer is
// the limit on sustained throughput. Up to 33 merged words are released
// per accepted word; any further ready words follow the next one. Results
// sit in a four-word output queue, so the sequencer keeps working while the
// consumer holds off pop, until that queue fills.
module streaming_two_run_merger (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [strm_pkg::WORD_W-1:0] word,
    input  logic                        push,
    output logic                        full,
    output logic [strm_pkg::WORD_W-1:0] merged_value,
    output logic                        group_end,
    output logic                        empty,
    input  logic                        pop
);

    logic           cmdq_push;
    strm_pkg::cmd_t cmdq_in;
    logic           cmdq_full;
    logic           cmdq_pop;
    strm_pkg::cmd_t cmdq_head;
    logic           cmdq_empty;

    // front end: header / terminator / data classification
    strm_intake u_intake (
        .clk       (clk),
        .rst_n     (rst_n),
        .word      (word),
        .push      (push),
        .full      (full),
        .cmdq_push (cmdq_push),
        .cmdq_cmd  (cmdq_in),
        .cmdq_full (cmdq_full)
    );

    // decouples intake from the merge sequencer
    strm_cmd_queue u_cmd_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmdq_push),
        .push_cmd (cmdq_in),
        .full     (cmdq_full),
        .pop      (cmdq_pop),
        .head_cmd (cmdq_head),
        .empty    (cmdq_empty)
    );

    // back end: run queues, merge and result queue
    strm_engine u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmdq_head),
        .cmd_empty    (cmdq_empty),
        .cmd_pop      (cmdq_pop),
        .merged_value (merged_value),
        .group_end    (group_end),
        .empty        (empty),
        .pop          (pop)
    );

endmodule

/* tb/streaming_two_run_merger_tb.sv */
// Self-checking testbench for the streaming two-run merger.
module streaming_two_run_merger_tb;

    // Run control
    localparam int LIMIT_CYCLES  = 2_000_000;  // far above the slowest legal run
    localparam int SETTLE_CYCLES = 200;        // quiet time after the last word is out
    localparam int CHOKE_AT      = 40;         // words taken before the long pop hold-off
    localparam int CHOKE_CYCLES  = 300;
    localparam int MAX_SHOWN     = 10;
    localparam int RANDOM_ITEMS  = 50;         // at least this many words of frames and noise
    localparam int FILL_FRAMES   = 30;         // one-word frames that pile words into run A
    localparam int LOCK_FRAMES   = 36;         // enough of them to overflow run A

    // Outcome of one merge engine action.
    typedef enum int {
        STALLED,
        MOVED,
        EMITTED
    } step_t;

    // Which queue the next data word is aimed at.
    typedef enum logic [1:0] {
        TAKE_HEADER,
        TAKE_A,
        TAKE_B
    } intake_t;

    // How the data words of a frame are made up.
    typedef enum int {
        FILL_SPREAD,   // full 32-bit range
        FILL_SORTED,   // ascending runs, with repeats
        FILL_NARROW,   // 0..3, so ties are common
        FILL_SPLIT     // run A low, run B high
    } fill_t;

    // A word waiting to be offered. hold makes the sender wait until every
    // expected merged word has come out before offering it.
    typedef struct {
        logic [strm_pkg::WORD_W-1:0] value;
        bit                          hold;
    } feed_t;

    logic                        clk   = 1'b0;
    logic                        rst_n = 1'b0;
    logic [strm_pkg::WORD_W-1:0] word  = '0;
    logic                        push  = 1'b0;
    logic                        full;
    logic [strm_pkg::WORD_W-1:0] merged_value;
    logic                        group_end;
    logic                        empty;
    logic                        pop   = 1'b0;

    streaming_two_run_merger u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .word         (word),
        .push         (push),
        .full         (full),
        .merged_value (merged_value),
        .group_end    (group_end),
        .empty        (empty),
        .pop          (pop)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: a copy of the intake, the two run queues and the
    // merge engine, advanced once per accepted word.
    // ------------------------------------------------------------------
    intake_t                     intake   = TAKE_HEADER;
    int                          run_len  = 0;
    logic [strm_pkg::WORD_W-1:0] run_a[$];
    logic [strm_pkg::WORD_W-1:0] run_b[$];
    strm_pkg::merge_phase_t      phase    = strm_pkg::PH_WAIT;
    logic [strm_pkg::WORD_W-1:0] head_a   = '0;
    logic [strm_pkg::WORD_W-1:0] head_b   = '0;
    int                          taken_a  = 0;
    int                          taken_b  = 0;

    strm_pkg::result_t           merged_due[$];   // merged words still to come, oldest first

    // Stimulus and handshake bookkeeping
    feed_t                       pending[$];
    bit                          gen_in_header = 1'b1;  // generator's view of the intake mode
    bit                          hold_next     = 1'b0;
    logic [strm_pkg::WORD_W-1:0] sort_base     = '0;

    bit                          took_word   = 1'b0;   // set at the rising edge, read at the falling one
    bit                          took_result = 1'b0;
    int                          words_sent  = 0;
    int                          faults      = 0;
    int                          cycle_count = 0;

    bit                          tx_push;
    logic [strm_pkg::WORD_W-1:0] tx_word;
    int                          tx_gap   = 0;
    int                          tx_calm  = 0;
    int                          rx_gap   = 0;
    int                          rx_calm  = 0;
    int                          choke_left = 0;
    bit                          choke_done = 1'b0;

    // Header to run length: 0 reads as 1, anything past the queue depth clips.
    function automatic int run_of(input logic [strm_pkg::WORD_W-1:0] hdr);
        if (hdr == '0)
            return 1;
        if (hdr > strm_pkg::QUEUE_DEPTH)
            return strm_pkg::QUEUE_DEPTH;
        return int'(hdr);
    endfunction

    // One engine action. The current run length is used throughout, so a
    // header that lands mid-merge changes the group at once.
    task automatic merge_step(output step_t act, output strm_pkg::result_t r);
        bit done;
        r   = '0;
        act = MOVED;
        case (phase)
            strm_pkg::PH_WAIT:
            begin
                if (run_a.size() == 0 || run_b.size() == 0)
                    act = STALLED;
                else
                begin
                    head_a  = run_a.pop_front();
                    head_b  = run_b.pop_front();
                    taken_a = 1;
                    taken_b = 1;
                    phase   = strm_pkg::PH_COMPARE;
                end
            end
            strm_pkg::PH_FETCH_A:
            begin
                if (run_a.size() == 0)
                    act = STALLED;
                else
                begin
                    head_a = run_a.pop_front();
                    taken_a++;
                    phase  = strm_pkg::PH_COMPARE;
                end
            end
            strm_pkg::PH_FETCH_B:
            begin
                if (run_b.size() == 0)
                    act = STALLED;
                else
                begin
                    head_b = run_b.pop_front();
                    taken_b++;
                    phase  = strm_pkg::PH_COMPARE;
                end
            end
            strm_pkg::PH_COMPARE:
            begin
                act = EMITTED;
                // strictly smaller A wins; a tie goes to B
                if (head_a < head_b)
                begin
                    r.value = head_a;
                    phase   = (taken_a < run_len) ? strm_pkg::PH_FETCH_A
                                                  : strm_pkg::PH_DRAIN_B;
                end
                else
                begin
                    r.value = head_b;
                    phase   = (taken_b < run_len) ? strm_pkg::PH_FETCH_B
                                                  : strm_pkg::PH_DRAIN_A;
                end
            end
            strm_pkg::PH_DFETCH_A:
            begin
                if (run_a.size() == 0)
                    act = STALLED;
                else
                begin
                    head_a = run_a.pop_front();
                    phase  = strm_pkg::PH_DRAIN_A;
                end
            end
            strm_pkg::PH_DFETCH_B:
            begin
                if (run_b.size() == 0)
                    act = STALLED;
                else
                begin
                    head_b = run_b.pop_front();
                    phase  = strm_pkg::PH_DRAIN_B;
                end
            end
            strm_pkg::PH_DRAIN_A:
            begin
                done    = !(taken_a < run_len);
                act     = EMITTED;
                r.value = head_a;
                r.last  = done;
                phase   = done ? strm_pkg::PH_WAIT : strm_pkg::PH_DFETCH_A;
                taken_a++;
            end
            default:
            begin
                done    = !(taken_b < run_len);
                act     = EMITTED;
                r.value = head_b;
                r.last  = done;
                phase   = done ? strm_pkg::PH_WAIT : strm_pkg::PH_DFETCH_B;
                taken_b++;
            end
        endcase
    endtask

    // Take one word into the intake, then run the engine until it stalls or
    // has released a full burst; anything beyond the burst waits for the
    // next word.
    task automatic predict_merge(input logic [strm_pkg::WORD_W-1:0] w);
        step_t             act;
        strm_pkg::result_t r;
        int                n;
        n = 0;
        if (intake == TAKE_HEADER)
        begin
            run_len = run_of(w);
            intake  = TAKE_A;
        end
        else if (w == strm_pkg::END_WORD)
            intake = TAKE_HEADER;
        else if (intake == TAKE_B)
        begin
            // a word for a full queue is lost and the next one tries again
            if (run_b.size() < strm_pkg::QUEUE_DEPTH)
            begin
                run_b.push_back(w);
                intake = TAKE_A;
            end
        end
        else if (run_a.size() < strm_pkg::QUEUE_DEPTH)
        begin
            run_a.push_back(w);
            intake = TAKE_B;
        end
        act = MOVED;
        while (n < strm_pkg::MAX_RESULTS && act != STALLED)
        begin
            merge_step(act, r);
            if (act == EMITTED)
            begin
                merged_due.push_back(r);
                n++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus generation
    // ------------------------------------------------------------------
    task automatic add_word(input logic [strm_pkg::WORD_W-1:0] w);
        feed_t f;
        f.value   = w;
        f.hold    = hold_next;
        hold_next = 1'b0;
        pending.push_back(f);
        if (gen_in_header)
            gen_in_header = 1'b0;
        else if (w == strm_pkg::END_WORD)
            gen_in_header = 1'b1;
    endtask

    // Data word number idx of a frame; the terminator value never appears.
    function automatic logic [strm_pkg::WORD_W-1:0] data_word(input fill_t fill,
                                                             input int idx);
        logic [strm_pkg::WORD_W-1:0] v;
        case (fill)
            FILL_SORTED:
            begin
                v         = sort_base;
                sort_base = sort_base + $urandom_range(0, 3);
            end
            FILL_NARROW:
                v = $urandom_range(0, 3);
            FILL_SPLIT:
                v = (idx % 2 == 0) ? 32'($urandom_range(0, 255))
                                   : (32'hFFFF_0000 | 32'($urandom_range(0, 255)));
            default:
                v = $urandom;
        endcase
        if (v == strm_pkg::END_WORD)
            v = strm_pkg::END_WORD - 1;
        return v;
    endfunction

    // Header, n data words, terminator. If the intake is still in data mode
    // a terminator goes first so the header is read as one.
    task automatic add_frame(input logic [strm_pkg::WORD_W-1:0] hdr, input int n,
                             input fill_t fill);
        if (!gen_in_header)
            add_word(strm_pkg::END_WORD);
        sort_base = $urandom_range(0, 1 << 20);
        add_word(hdr);
        for (int i = 0; i < n; i++)
            add_word(data_word(fill, i));
        add_word(strm_pkg::END_WORD);
    endtask

    // Mostly short runs; now and then the full depth or a wild value.
    function automatic logic [strm_pkg::WORD_W-1:0] pick_header();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 60)
            return $urandom_range(1, 4);
        if (r < 82)
            return $urandom_range(5, 8);
        if (r < 92)
            return $urandom_range(9, 16);
        if (r < 96)
            return strm_pkg::QUEUE_DEPTH;
        return $urandom;
    endfunction

    // Idle length between words: mostly none, some short, a few long,
    // with occasional calm stretches of back-to-back traffic.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    task automatic log_fault(input string what, input strm_pkg::result_t want,
                             input strm_pkg::result_t got);
        if (faults < MAX_SHOWN)
            $display("%s: expected %h last=%0b, got %h last=%0b",
                     what, want.value, want.last, got.value, got.last);
        faults++;
    endtask

    // ------------------------------------------------------------------
    // Sender: offers pending words at the falling edge. push stays up
    // until the word is taken; the next word may follow straight away.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            push <= 1'b0;
        else
        begin
            tx_push = push;
            tx_word = word;
            if (push && took_word)
                tx_push = 1'b0;
            if (!tx_push)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (pending.size() != 0 && !(pending[0].hold && merged_due.size() != 0))
                begin
                    tx_word = pending[0].value;
                    tx_push = 1'b1;
                    void'(pending.pop_front());
                    tx_gap  = pick_gap(tx_calm);
                end
            end
            push <= tx_push;
            word <= tx_word;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: drops pop for a random gap after each word, and once holds
    // it off for a long stretch so the block backs up and raises full.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
        begin
            if (took_result)
                rx_gap = pick_gap(rx_calm);
            if (choke_left > 0)
            begin
                choke_left--;
                pop <= 1'b0;
            end
            else if (!choke_done && words_sent >= CHOKE_AT)
            begin
                choke_done = 1'b1;
                choke_left = CHOKE_CYCLES;
                pop <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: at the rising edge, feeds accepted words to the predictor
    // and checks each popped word against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        strm_pkg::result_t want;
        strm_pkg::result_t got;
        took_word   = 1'b0;
        took_result = 1'b0;
        if (rst_n)
        begin
            if (push && !full)
            begin
                took_word = 1'b1;
                words_sent++;
                predict_merge(word);
            end
            if (pop && !empty)
            begin
                took_result = 1'b1;
                got.value   = merged_value;
                got.last    = group_end;
                if (merged_due.size() == 0)
                    log_fault("unexpected word", '0, got);
                else
                begin
                    want = merged_due.pop_front();
                    if (want.value !== got.value || want.last !== got.last)
                        log_fault("mismatch", want, got);
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles, %0d words outstanding",
                     cycle_count, merged_due.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Build the stimulus, release reset, then wait for the run to drain.
    // ------------------------------------------------------------------
    initial
    begin
        int          r;
        logic [31:0] hdr;
        int          k;

        // Directed part.
        // Zero header gives L = 1; B's smaller head goes first, A drains.
        add_word(32'd0); add_word(32'd7); add_word(32'd3); add_word(strm_pkg::END_WORD);
        // Equal heads: the B word wins the tie.
        add_word(32'd1); add_word(32'd9); add_word(32'd9); add_word(strm_pkg::END_WORD);
        // Terminator read as a header clips to the depth; field extremes.
        add_word(strm_pkg::END_WORD); add_word(32'd0); add_word(32'hFFFF_FFFE);
        add_word(strm_pkg::END_WORD);
        // New header while the long group is part-way: L = 2 applies at once.
        add_word(32'd2); add_word(32'd1); add_word(32'd2); add_word(strm_pkg::END_WORD);
        // Header past the depth clips to it; top bit patterns.
        add_word(32'd33); add_word(32'h8000_0000); add_word(32'h7FFF_FFFF);
        add_word(strm_pkg::END_WORD);
        // Odd frame leaves a word queued in run A for later groups.
        add_word(32'd3); add_word(32'd5); add_word(32'd4); add_word(32'd6);
        add_word(strm_pkg::END_WORD);

        // Random part: mostly whole frames, some short or odd ones, some noise.
        hold_next = 1'b1;
        k = pending.size() + RANDOM_ITEMS;
        while (pending.size() < k)
        begin
            r = $urandom_range(0, 99);
            if (r < 72)
            begin
                hdr = pick_header();
                add_frame(hdr, 2 * run_of(hdr), fill_t'($urandom_range(0, 3)));
            end
            else if (r < 88)
            begin
                hdr = pick_header();
                add_frame(hdr, $urandom_range(0, 2 * run_of(hdr) + 1),
                          fill_t'($urandom_range(0, 3)));
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    add_word(($urandom_range(0, 9) < 3) ? strm_pkg::END_WORD
                                                        : 32'($urandom));
            end
        end

        // One-word frames only ever feed run A, so it piles up while the
        // engine waits on B. A long group with low A words and high B words
        // then releases a large burst of merged words at once.
        hold_next = 1'b1;
        repeat (FILL_FRAMES)
            add_frame(32'd1, 1, FILL_SPLIT);
        add_frame(strm_pkg::QUEUE_DEPTH, 8, FILL_SPLIT);

        // Finally overflow run A. Once it is full every data word is lost
        // and B never gets fed again, so this has to come last.
        repeat (LOCK_FRAMES)
            add_frame(32'd1, 1, FILL_SPLIT);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || push)
            @(posedge clk);
        while (merged_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (merged_due.size() != 0)
        begin
            $display("%0d merged words never arrived", merged_due.size());
            faults++;
        end
        if (faults == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
